// File: hw/rtl/dns_question_name_extractor_defines.svh
// Assertion macros used by the checker file of the DNS question name extractor.
`ifndef DNS_QUESTION_NAME_EXTRACTOR_DEFINES_SVH
`define DNS_QUESTION_NAME_EXTRACTOR_DEFINES_SVH

// Clocked assertion, inactive while reset is asserted.
`define DQNE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DQNE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dqne_pkg.sv
// Types and constants of the DNS question name extractor.
`default_nettype none
package dqne_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  localparam logic [15:0] DEFAULT_MAX_QUERIES = 16'd100;
  localparam logic [7:0]  DOT_CHAR            = 8'h2E;
  localparam logic [2:0]  TYPE_CLASS_BYTES    = 3'd4;
  localparam int          HEADER_BYTES        = 12;
  localparam int          COUNT_HI_OFFSET     = 4;
  localparam int          COUNT_LO_OFFSET     = 5;

  // Result stream layout
  localparam int CHAR_W      = 8;
  localparam int TAG_W       = 64;
  localparam int OUT_TDATA_W = CHAR_W + TAG_W;

  // Result buffer
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              name_end;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/dns_question_name_extractor.sv
// Results of an accepted byte are written into the result buffer and are output from there.
// Throughput: one byte per cycle while each byte yields at most one result and the output
//   is not stalled; a byte that yields two results (dot or character plus name end) is absorbed
//   by the four-entry result buffer, whose fill level is what limits input acceptance.
// Reset (rst_n low, synchronous): parser returns to header phase at offset 0, buffer empties,
//   max_queries returns to 100.
`default_nettype none
module dns_question_name_extractor
  import dqne_pkg::*;
#(
  parameter int LENGTH_BITS = 16,
  localparam int IN_TDATA_W = ((8 + LENGTH_BITS + TAG_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // data_byte[7:0], packet_length[LENGTH_BITS+7:8], thread_id above, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // char_out[7:0], tag_out[71:8]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,   // name_end
  output logic                        out_tlast,   // last_of_run
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [15:0]            cfg_wdata
);

  localparam int L = LENGTH_BITS;

  // Input fields
  logic [7:0]       data_byte;
  logic [L-1:0]     packet_length;
  logic [TAG_W-1:0] thread_id;
  assign data_byte     = in_tdata[7:0];
  assign packet_length = in_tdata[L+7:8];
  assign thread_id     = in_tdata[L+8+TAG_W-1:L+8];

  // Parser state
  logic [15:0]  max_queries_r;
  logic [L-1:0] byte_offset_r,      byte_offset_nxt;
  logic [2:0]   parse_phase_r,      parse_phase_nxt;
  logic [7:0]   count_high_byte_r,  count_high_byte_nxt;
  logic [15:0]  queries_left_r,     queries_left_nxt;
  logic [7:0]   label_bytes_left_r, label_bytes_left_nxt;
  logic         name_nonempty_r,    name_nonempty_nxt;
  logic [2:0]   skip_bytes_left_r,  skip_bytes_left_nxt;

  // Results of the current byte
  res_t       res_a, res_b;
  logic [1:0] res_n;

  // Result buffer
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  logic in_xfer, out_xfer;
  logic [1:0] push_n;

  assign in_tready  = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_xfer   = out_tvalid && out_tready;
  assign push_n     = in_xfer ? res_n : 2'd0;

  assign out_tdata = {fifo_r[rd_ptr_r].tag, fifo_r[rd_ptr_r].ch};
  assign out_tuser = fifo_r[rd_ptr_r].name_end;
  assign out_tlast = fifo_r[rd_ptr_r].last;

  // Parse one byte: next state and up to two results
  always_comb begin
    logic [L:0] off_plus_len;
    logic [L:0] off_plus_one;
    res_t       item;
    byte_offset_nxt      = byte_offset_r;
    parse_phase_nxt      = parse_phase_r;
    count_high_byte_nxt  = count_high_byte_r;
    queries_left_nxt     = queries_left_r;
    label_bytes_left_nxt = label_bytes_left_r;
    name_nonempty_nxt    = name_nonempty_r;
    skip_bytes_left_nxt  = skip_bytes_left_r;
    res_a = '0;
    res_b = '0;
    res_n = 2'd0;
    item  = '0;
    off_plus_len = {1'b0, byte_offset_r} + (L+1)'(data_byte);
    off_plus_one = {1'b0, byte_offset_r} + (L+1)'(1);

    if (packet_length == '0) begin
      // Zero length: restart at the header, no result
      byte_offset_nxt      = '0;
      parse_phase_nxt      = PH_HEADER;
      count_high_byte_nxt  = '0;
      queries_left_nxt     = '0;
      label_bytes_left_nxt = '0;
      name_nonempty_nxt    = 1'b0;
      skip_bytes_left_nxt  = '0;
    end else begin
      case (parse_phase_r)
        PH_HEADER: begin
          if (byte_offset_r == L'(COUNT_HI_OFFSET)) begin
            count_high_byte_nxt = data_byte;
          end
          if (byte_offset_r == L'(COUNT_LO_OFFSET)) begin
            queries_left_nxt = {count_high_byte_r, data_byte};
            if ({count_high_byte_r, data_byte} > max_queries_r) begin
              parse_phase_nxt = PH_IDLE;
            end
          end
          if (byte_offset_r == L'(HEADER_BYTES - 1) && parse_phase_nxt == PH_HEADER) begin
            parse_phase_nxt = (queries_left_nxt != '0) ? PH_LEN : PH_IDLE;
          end
        end
        PH_LEN: begin
          if (data_byte == '0) begin
            // Root label: close the name, then skip type and class
            if (name_nonempty_r) begin
              item = '0;
              item.name_end = 1'b1;
              item.tag = thread_id;
              res_a = item;
              res_n = 2'd1;
            end
            name_nonempty_nxt   = 1'b0;
            queries_left_nxt    = queries_left_r - 16'd1;
            skip_bytes_left_nxt = TYPE_CLASS_BYTES;
            parse_phase_nxt     = PH_SKIP;
          end else begin
            if (name_nonempty_r) begin
              item = '0;
              item.ch = DOT_CHAR;
              res_a = item;
              res_n = 2'd1;
            end
            if (off_plus_len >= {1'b0, packet_length}) begin
              // Label runs past the packet: close the name, ignore the rest
              if (name_nonempty_r) begin
                item = '0;
                item.name_end = 1'b1;
                item.tag = thread_id;
                res_b = item;
                res_n = 2'd2;
              end
              name_nonempty_nxt = 1'b0;
              parse_phase_nxt   = PH_IDLE;
            end else begin
              label_bytes_left_nxt = data_byte;
              name_nonempty_nxt    = 1'b1;
              parse_phase_nxt      = PH_LABEL;
            end
          end
        end
        PH_LABEL: begin
          item = '0;
          item.ch = data_byte;
          res_a = item;
          res_n = 2'd1;
          label_bytes_left_nxt = label_bytes_left_r - 8'd1;
          if (label_bytes_left_nxt == '0) begin
            parse_phase_nxt = PH_LEN;
          end
        end
        PH_SKIP: begin
          skip_bytes_left_nxt = skip_bytes_left_r - 3'd1;
          if (skip_bytes_left_nxt == '0) begin
            parse_phase_nxt = (queries_left_r != '0) ? PH_LEN : PH_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (off_plus_one >= {1'b0, packet_length}) begin
        // Packet end: close a pending name and restart
        if (name_nonempty_nxt) begin
          item = '0;
          item.name_end = 1'b1;
          item.tag = thread_id;
          if (res_n == 2'd0) begin
            res_a = item;
          end else begin
            res_b = item;
          end
          res_n = res_n + 2'd1;
        end
        byte_offset_nxt      = '0;
        parse_phase_nxt      = PH_HEADER;
        count_high_byte_nxt  = '0;
        queries_left_nxt     = '0;
        label_bytes_left_nxt = '0;
        name_nonempty_nxt    = 1'b0;
        skip_bytes_left_nxt  = '0;
      end else begin
        byte_offset_nxt = off_plus_one[L-1:0];
      end
    end

    // Mark the final result of this byte
    if (res_n == 2'd1) begin
      res_a.last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  // Hold configuration and parser state, advance on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_queries_r      <= DEFAULT_MAX_QUERIES;
      byte_offset_r      <= '0;
      parse_phase_r      <= PH_HEADER;
      count_high_byte_r  <= '0;
      queries_left_r     <= '0;
      label_bytes_left_r <= '0;
      name_nonempty_r    <= 1'b0;
      skip_bytes_left_r  <= '0;
    end else begin
      if (cfg_we) begin
        max_queries_r <= cfg_wdata;
      end
      if (in_xfer) begin
        byte_offset_r      <= byte_offset_nxt;
        parse_phase_r      <= parse_phase_nxt;
        count_high_byte_r  <= count_high_byte_nxt;
        queries_left_r     <= queries_left_nxt;
        label_bytes_left_r <= label_bytes_left_nxt;
        name_nonempty_r    <= name_nonempty_nxt;
        skip_bytes_left_r  <= skip_bytes_left_nxt;
      end
    end
  end

  // Store results in the buffer
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res_b;
    end
  end

  // Advance buffer pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(out_xfer);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dqne_checker.sv
// Port-level checks of the DNS question name extractor, bound to the top level.
`default_nettype none
`include "dns_question_name_extractor_defines.svh"
module dqne_checker
  import dqne_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   out_tlast,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  // Stalled result holds
  `DQNE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  // Name end carries no character and closes the run of its byte
  `DQNE_ASSERT(a_end_char, out_tvalid && out_tuser |-> out_tdata[CHAR_W-1:0] == '0 && out_tlast, "name end item malformed")
  // Character items carry no tag
  `DQNE_ASSERT(a_char_tag, out_tvalid && !out_tuser |-> out_tdata[OUT_TDATA_W-1:CHAR_W] == '0, "character item carries a tag")
  // Reset empties the result buffer
  `DQNE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind dns_question_name_extractor dqne_checker u_dqne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
